// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by swr_ctrl.
// Each macro declares one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/swr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_pkg
// Types and codes for the stop-and-wait retransmit controller.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned ATTEMPT_W = 4;
  localparam int unsigned POLL_W    = 10;
  localparam int unsigned CFG_W     = 10;

  // Configuration register indexes.
  localparam logic CFG_MAX_RETRIES   = 1'b0;
  localparam logic CFG_TIMEOUT_POLLS = 1'b1;

  // Configuration reset values.
  localparam logic [ATTEMPT_W-1:0] MAX_RETRIES_RST   = 4'd3;
  localparam logic [POLL_W-1:0]    TIMEOUT_POLLS_RST = 10'd40;

  // Input event codes.
  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_ACK      = 2'd1,
    MODE_POLL     = 2'd2,
    MODE_LINK_ERR = 2'd3
  } mode_t;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_TRANSMIT  = 3'd0,
    EV_DELIVERED = 3'd1,
    EV_FAILED    = 3'd2,
    EV_LINK_ERR  = 3'd3,
    EV_REJECTED  = 3'd4
  } event_t;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  // One registered input item.
  typedef struct packed {
    logic              valid;
    mode_t             mode;
    logic [ID_W-1:0]   id;
  } item_t;

endpackage

// ===== rtl/core/swr_input_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_input_stage
// Input register that captures one event item and holds it until the
// controller takes it.
// ----------------------------------------------------------------------------
module swr_input_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               mode,
  input  logic [swr_pkg::ID_W-1:0] msg_id,
  input  logic                     take,
  output swr_pkg::item_t           item
);

  swr_pkg::item_t held;

  // Stall only when a held item is not taken this cycle.
  assign in_stall = held.valid && !take;

  // Load a new item whenever the register is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (!in_stall) begin
      held.valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      held.mode <= swr_pkg::mode_t'(mode);
      held.id   <= msg_id;
    end
  end

  assign item = held;

endmodule

// ===== rtl/core/swr_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// swr_ctrl
// Retransmit state machine, configuration registers and result register.
// Each taken item updates the state and loads at most one result.
// ----------------------------------------------------------------------------
module swr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [swr_pkg::CFG_W-1:0]     cfg_data,
  input  swr_pkg::item_t                item,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_kind,
  output logic [swr_pkg::ID_W-1:0]      out_id,
  output logic [swr_pkg::ATTEMPT_W-1:0] attempt_no
);

  // Configuration registers.
  logic [swr_pkg::ATTEMPT_W-1:0] max_retries;
  logic [swr_pkg::POLL_W-1:0]    timeout_polls;

  // Controller state.
  swr_pkg::state_t               state, state_next;
  logic [swr_pkg::ID_W-1:0]      pending_id, pending_id_next;
  logic                          acked, acked_next;
  logic [swr_pkg::ATTEMPT_W-1:0] attempt_count, attempt_count_next;
  logic [swr_pkg::POLL_W-1:0]    poll_count, poll_count_next;

  // Result computed for the current item.
  logic                          emit;
  swr_pkg::event_t               kind_res;
  swr_pkg::event_t               kind_reg;
  logic [swr_pkg::ID_W-1:0]      id_res;
  logic [swr_pkg::ATTEMPT_W-1:0] att_res;

  logic [swr_pkg::POLL_W-1:0]    poll_inc;
  logic [swr_pkg::POLL_W-1:0]    limit;
  logic                          still_waiting;
  logic                          is_busy;

  assign is_busy       = (state == swr_pkg::ST_BUSY);
  assign poll_inc      = poll_count + {{(swr_pkg::POLL_W-1){1'b0}}, 1'b1};
  assign limit         = (timeout_polls == '0) ? {{(swr_pkg::POLL_W-1){1'b0}}, 1'b1}
                                               : timeout_polls;
  assign still_waiting = (poll_inc != '0) && (poll_inc < limit);

  // Next state and result for the item in the input register.
  always_comb begin
    state_next         = state;
    pending_id_next    = pending_id;
    acked_next         = acked;
    attempt_count_next = attempt_count;
    poll_count_next    = poll_count;
    emit               = 1'b0;
    kind_res           = swr_pkg::EV_TRANSMIT;
    id_res             = item.id;
    att_res            = attempt_count;
    case (item.mode)
      swr_pkg::MODE_START: begin
        emit = 1'b1;
        if (is_busy) begin
          kind_res = swr_pkg::EV_REJECTED;
        end else begin
          state_next         = swr_pkg::ST_BUSY;
          pending_id_next    = item.id;
          acked_next         = 1'b0;
          attempt_count_next = '0;
          poll_count_next    = '0;
          att_res            = '0;
        end
      end
      swr_pkg::MODE_ACK: begin
        if (is_busy && (item.id == pending_id)) begin
          acked_next = 1'b1;
        end
      end
      swr_pkg::MODE_POLL: begin
        if (is_busy) begin
          id_res = pending_id;
          if (acked) begin
            emit     = 1'b1;
            kind_res = swr_pkg::EV_DELIVERED;
            state_next         = swr_pkg::ST_IDLE;
            acked_next         = 1'b0;
            attempt_count_next = '0;
            poll_count_next    = '0;
          end else begin
            poll_count_next = poll_inc;
            if (!still_waiting) begin
              emit = 1'b1;
              if (attempt_count < max_retries) begin
                attempt_count_next = attempt_count + {{(swr_pkg::ATTEMPT_W-1){1'b0}}, 1'b1};
                poll_count_next    = '0;
                kind_res           = swr_pkg::EV_TRANSMIT;
                att_res            = attempt_count_next;
              end else begin
                kind_res           = swr_pkg::EV_FAILED;
                state_next         = swr_pkg::ST_IDLE;
                acked_next         = 1'b0;
                attempt_count_next = '0;
                poll_count_next    = '0;
              end
            end
          end
        end
      end
      swr_pkg::MODE_LINK_ERR: begin
        if (is_busy) begin
          emit               = 1'b1;
          kind_res           = swr_pkg::EV_LINK_ERR;
          id_res             = pending_id;
          state_next         = swr_pkg::ST_IDLE;
          acked_next         = 1'b0;
          attempt_count_next = '0;
          poll_count_next    = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // An item moves on unless its result would overwrite a waiting one.
  assign take = item.valid && (!out_valid || !out_stall || !emit);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries   <= swr_pkg::MAX_RETRIES_RST;
      timeout_polls <= swr_pkg::TIMEOUT_POLLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swr_pkg::CFG_MAX_RETRIES:   max_retries   <= cfg_data[swr_pkg::ATTEMPT_W-1:0];
        swr_pkg::CFG_TIMEOUT_POLLS: timeout_polls <= cfg_data[swr_pkg::POLL_W-1:0];
        default: begin
          max_retries <= max_retries;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= swr_pkg::ST_IDLE;
      pending_id    <= '0;
      acked         <= 1'b0;
      attempt_count <= '0;
      poll_count    <= '0;
    end else if (take) begin
      state         <= state_next;
      pending_id    <= pending_id_next;
      acked         <= acked_next;
      attempt_count <= attempt_count_next;
      poll_count    <= poll_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (take && emit) begin
      kind_reg   <= kind_res;
      out_id     <= id_res;
      attempt_no <= att_res;
    end
  end

  assign event_kind = kind_reg;

  // Terms used by the checks below.
  logic idle_clear;
  logic start_idle;
  logic final_wait;

  assign idle_clear = !acked && (attempt_count == '0) && (poll_count == '0);
  assign start_idle = take && (item.mode == swr_pkg::MODE_START) && !is_busy;
  assign final_wait = out_valid && (kind_reg inside {swr_pkg::EV_DELIVERED,
                                                     swr_pkg::EV_FAILED,
                                                     swr_pkg::EV_LINK_ERR});

  // Idle means all per-message counters are clear.
  `SWR_ASSERT_SAME(a_idle_clear, clk, rst, state == swr_pkg::ST_IDLE, idle_clear)
  // A start taken while idle arms the block with the new id.
  `SWR_ASSERT_NEXT(a_start_arms, clk, rst, start_idle, is_busy && pending_id == $past(item.id))
  // A waiting terminal result implies the block is idle.
  `SWR_ASSERT_SAME(a_final_idle, clk, rst, final_wait, state == swr_pkg::ST_IDLE)

endmodule

// ===== rtl/core/stop_and_wait_retransmit.sv =====
`timescale 1ns / 1ps
// Flow: an accepted item waits in the input register, and the result register
// loads from it when the controller takes the item.
// Throughput: one item per cycle unless out_stall holds a result; the input
// and result registers let the next item enter while a result waits to be taken.
// Reset: synchronous, active high; block idle, max_retries 3, timeout_polls 40.
// ----------------------------------------------------------------------------
// stop_and_wait_retransmit
// Sender side of a stop-and-wait delivery scheme with one outstanding
// message: transmit, ack tracking, poll timeout, retransmit and failure.
// ----------------------------------------------------------------------------
module stop_and_wait_retransmit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [swr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [swr_pkg::ID_W-1:0]      msg_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_kind,
  output logic [swr_pkg::ID_W-1:0]      out_id,
  output logic [swr_pkg::ATTEMPT_W-1:0] attempt_no
);

  swr_pkg::item_t item;
  logic           take;

  // Event input register.
  swr_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .msg_id   (msg_id),
    .take     (take),
    .item     (item)
  );

  // Controller and result register.
  swr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .out_id     (out_id),
    .attempt_no (attempt_no)
  );

endmodule

// ===== tb/sv/stop_and_wait_retransmit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_and_wait_retransmit_tb
// Self-checking bench for the stop-and-wait retransmit controller. A short
// table of directed items runs first, then random message exchanges (start,
// polls, matching and foreign acks, busy starts, link errors) under several
// register settings. An item-level model of the controller predicts every
// report, and the monitor compares each accepted report in order, while both
// handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module stop_and_wait_retransmit_tb;

  localparam int LATENCY      = 2;
  localparam int RANDOM_ITEMS = 1925;
  localparam int MAX_STEPS    = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  // One report of the controller.
  typedef struct packed {
    swr_pkg::event_t          kind;
    logic [swr_pkg::ID_W-1:0] id;
    logic [3:0]               attempt;
  } report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item, or a register write.
  typedef struct packed {
    row_kind_t                 kind;
    swr_pkg::mode_t            mode;
    logic [swr_pkg::ID_W-1:0]  id;
    bit                        typed;
    bit                        typed_has;
    report_t                   rep;
    logic                      cfg_idx;
    logic [swr_pkg::CFG_W-1:0] cfg_val;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic                          cfg_index;
  logic [swr_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    mode;
  logic [swr_pkg::ID_W-1:0]      msg_id;
  logic                          out_valid;
  logic                          out_stall;
  logic [2:0]                    event_kind;
  logic [swr_pkg::ID_W-1:0]      out_id;
  logic [swr_pkg::ATTEMPT_W-1:0] attempt_no;

  // Predictor copy of the controller state and registers.
  logic [swr_pkg::ATTEMPT_W-1:0] lim_retries = swr_pkg::MAX_RETRIES_RST;
  logic [swr_pkg::POLL_W-1:0]    lim_polls   = swr_pkg::TIMEOUT_POLLS_RST;
  bit                            armed       = 1'b0;
  logic [swr_pkg::ID_W-1:0]      held_id     = '0;
  bit                            ack_seen    = 1'b0;
  logic [swr_pkg::ATTEMPT_W-1:0] tries       = '0;
  logic [swr_pkg::POLL_W-1:0]    ticks       = '0;

  report_t pending_reports[$];
  row_t    plan[$];
  int      mismatches     = 0;
  int      reports_seen   = 0;
  int      events_applied = 0;
  int      cycle_count    = 0;
  bit      steady         = 1'b0;

  stop_and_wait_retransmit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .msg_id     (msg_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .out_id     (out_id),
    .attempt_no (attempt_no)
  );

  always #5 clk = ~clk;

  // The pending message is dropped; the last id is kept.
  function automatic void drop_message();
    armed    = 1'b0;
    ack_seen = 1'b0;
    tries    = '0;
    ticks    = '0;
  endfunction

  // Advances the predicted state by one item and tells whether it reports.
  function automatic bit next_report(input swr_pkg::mode_t m,
                                     input logic [swr_pkg::ID_W-1:0] id,
                                     output report_t rep);
    logic [swr_pkg::POLL_W-1:0] lim;
    rep = '0;
    case (m)
      swr_pkg::MODE_START: begin
        if (armed) begin
          rep = '{kind: swr_pkg::EV_REJECTED, id: id, attempt: tries};
          return 1'b1;
        end
        armed    = 1'b1;
        held_id  = id;
        ack_seen = 1'b0;
        tries    = '0;
        ticks    = '0;
        rep = '{kind: swr_pkg::EV_TRANSMIT, id: id, attempt: 4'd0};
        return 1'b1;
      end
      swr_pkg::MODE_ACK: begin
        if (armed && id == held_id) ack_seen = 1'b1;
        return 1'b0;
      end
      swr_pkg::MODE_POLL: begin
        if (!armed) return 1'b0;
        // A recorded ack wins over a timeout on the same tick.
        if (ack_seen) begin
          rep = '{kind: swr_pkg::EV_DELIVERED, id: held_id, attempt: tries};
          drop_message();
          return 1'b1;
        end
        lim   = (lim_polls == '0) ? 10'd1 : lim_polls;
        ticks = ticks + 10'd1;
        if (ticks != '0 && ticks < lim) return 1'b0;
        if (tries < lim_retries) begin
          tries = tries + 4'd1;
          ticks = '0;
          rep = '{kind: swr_pkg::EV_TRANSMIT, id: held_id, attempt: tries};
          return 1'b1;
        end
        rep = '{kind: swr_pkg::EV_FAILED, id: held_id, attempt: tries};
        drop_message();
        return 1'b1;
      end
      default: begin
        if (!armed) return 1'b0;
        rep = '{kind: swr_pkg::EV_LINK_ERR, id: held_id, attempt: tries};
        drop_message();
        return 1'b1;
      end
    endcase
  endfunction

  // Table rows: item checked by the predictor, item with a typed report,
  // and register write.
  function automatic row_t item_row(input swr_pkg::mode_t m,
                                    input logic [swr_pkg::ID_W-1:0] id);
    row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.mode = m;
    row.id   = id;
    return row;
  endfunction

  function automatic row_t typed_row(input swr_pkg::mode_t m,
                                     input logic [swr_pkg::ID_W-1:0] id,
                                     input bit has, input swr_pkg::event_t k,
                                     input logic [swr_pkg::ID_W-1:0] rid,
                                     input logic [3:0] att);
    row_t row;
    row = item_row(m, id);
    row.typed     = 1'b1;
    row.typed_has = has;
    row.rep       = '{kind: k, id: rid, attempt: att};
    return row;
  endfunction

  function automatic row_t cfg_row(input logic idx, input logic [swr_pkg::CFG_W-1:0] val);
    row_t row;
    row = '0;
    row.kind    = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input row_t row);
    plan = {plan, row};
  endfunction

  // Offers one item after a random gap, waits for acceptance and records
  // the report it should cause.
  task automatic send_item(input swr_pkg::mode_t m, input logic [swr_pkg::ID_W-1:0] id,
                           input bit typed, input bit typed_has,
                           input report_t typed_rep);
    int      gap;
    int      r;
    bit      has;
    report_t rep;
    r = $urandom_range(0, 99);
    if (steady || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 2);
    else if (r < 98) gap = $urandom_range(3, 8);
    else gap = $urandom_range(15, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    msg_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = next_report(m, id, rep);
    if (typed) begin
      has = typed_has;
      rep = typed_rep;
    end
    if (has) pending_reports = {pending_reports, rep};
    events_applied++;
  endtask

  task automatic offer(input swr_pkg::mode_t m, input logic [swr_pkg::ID_W-1:0] id);
    send_item(m, id, 1'b0, 1'b0, '0);
  endtask

  // Registers change only once the pipeline has drained.
  task automatic write_register(input logic idx, input logic [swr_pkg::CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swr_pkg::CFG_MAX_RETRIES) lim_retries = val[swr_pkg::ATTEMPT_W-1:0];
    else lim_polls = val;
  endtask

  // One message from start to its end, with acks, polls and noise mixed in.
  task automatic run_message();
    int                       ack_pct;
    int                       r;
    int                       steps;
    logic [swr_pkg::ID_W-1:0] id;
    r = $urandom_range(0, 9);
    if (r == 0) id = '0;
    else if (r == 1) id = '1;
    else id = $urandom;
    case ($urandom_range(0, 4))
      0: ack_pct = 0;
      1: ack_pct = 2;
      2: ack_pct = 6;
      3: ack_pct = 15;
      default: ack_pct = 40;
    endcase
    steady = ($urandom_range(0, 3) == 0);
    offer(swr_pkg::MODE_START, id);
    steps = 0;
    while (armed && steps < MAX_STEPS && events_applied < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < ack_pct) begin
        offer(swr_pkg::MODE_ACK, held_id);
      end else if (r < ack_pct + 6) begin
        offer(swr_pkg::MODE_ACK, held_id ^ (32'h1 << $urandom_range(0, 31)));
      end else if (r < ack_pct + 10) begin
        offer(swr_pkg::MODE_START, $urandom);
      end else if (r < ack_pct + 12) begin
        offer(swr_pkg::MODE_LINK_ERR, $urandom);
      end else begin
        offer(swr_pkg::MODE_POLL, $urandom);
      end
      steps++;
    end
    if (armed) offer(swr_pkg::MODE_LINK_ERR, $urandom);
  endtask

  // Main stimulus: reset, directed table, random phases, then the drain.
  initial begin : stimulus
    int                        phase_left;
    int                        r;
    logic [swr_pkg::CFG_W-1:0] val;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    mode      <= swr_pkg::MODE_POLL;
    msg_id    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings first: idle items, busy start, foreign ack, delivery, link error.
    add_row(typed_row(swr_pkg::MODE_POLL, 32'h0, 1'b0, swr_pkg::EV_TRANSMIT, '0, '0));
    add_row(typed_row(swr_pkg::MODE_ACK, 32'hFFFF_FFFF, 1'b0, swr_pkg::EV_TRANSMIT,
                      '0, '0));
    add_row(typed_row(swr_pkg::MODE_LINK_ERR, 32'h0, 1'b0, swr_pkg::EV_TRANSMIT,
                      '0, '0));
    add_row(typed_row(swr_pkg::MODE_START, 32'hFFFF_FFFF, 1'b1, swr_pkg::EV_TRANSMIT,
                      32'hFFFF_FFFF, 4'd0));
    add_row(typed_row(swr_pkg::MODE_START, 32'h0, 1'b1, swr_pkg::EV_REJECTED,
                      32'h0, 4'd0));
    add_row(item_row(swr_pkg::MODE_ACK, 32'h1234_5678));
    add_row(item_row(swr_pkg::MODE_POLL, 32'h0));
    add_row(item_row(swr_pkg::MODE_ACK, 32'hFFFF_FFFF));
    add_row(typed_row(swr_pkg::MODE_POLL, 32'h0, 1'b1, swr_pkg::EV_DELIVERED,
                      32'hFFFF_FFFF, 4'd0));
    add_row(item_row(swr_pkg::MODE_START, 32'h0));
    add_row(typed_row(swr_pkg::MODE_LINK_ERR, 32'h0, 1'b1, swr_pkg::EV_LINK_ERR,
                      32'h0, 4'd0));
    // No resends and a zero timeout, which acts as one tick.
    add_row(cfg_row(swr_pkg::CFG_MAX_RETRIES, 10'd0));
    add_row(cfg_row(swr_pkg::CFG_TIMEOUT_POLLS, 10'd0));
    add_row(item_row(swr_pkg::MODE_START, 32'hA5A5_A5A5));
    add_row(typed_row(swr_pkg::MODE_POLL, 32'h0, 1'b1, swr_pkg::EV_FAILED,
                      32'hA5A5_A5A5, 4'd0));
    // Most resends; an ack lands on a tick that would time out.
    add_row(cfg_row(swr_pkg::CFG_MAX_RETRIES, 10'h3FF));
    add_row(cfg_row(swr_pkg::CFG_TIMEOUT_POLLS, 10'd1));
    add_row(item_row(swr_pkg::MODE_START, 32'h5A5A_5A5A));
    add_row(item_row(swr_pkg::MODE_POLL, 32'h0));
    add_row(item_row(swr_pkg::MODE_ACK, 32'h5A5A_5A5A));
    add_row(item_row(swr_pkg::MODE_POLL, 32'h0));
    // One resend, two ticks per attempt, run out to failure.
    add_row(cfg_row(swr_pkg::CFG_MAX_RETRIES, 10'd1));
    add_row(cfg_row(swr_pkg::CFG_TIMEOUT_POLLS, 10'd2));
    add_row(item_row(swr_pkg::MODE_START, 32'h0F0F_0F0F));
    repeat (4) add_row(item_row(swr_pkg::MODE_POLL, 32'hFFFF_FFFF));
    // Longest timeout, acked early.
    add_row(cfg_row(swr_pkg::CFG_TIMEOUT_POLLS, 10'h3FF));
    add_row(item_row(swr_pkg::MODE_START, 32'hF0F0_F0F0));
    add_row(item_row(swr_pkg::MODE_ACK, 32'hF0F0_F0F0));
    add_row(item_row(swr_pkg::MODE_POLL, 32'h0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_register(plan[i].cfg_idx, plan[i].cfg_val);
      else send_item(plan[i].mode, plan[i].id, plan[i].typed, plan[i].typed_has,
                     plan[i].rep);
    end

    // Random phases, each under its own register setting.
    events_applied = 0;
    phase_left = 0;
    while (events_applied < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        val = 10'($urandom_range(0, 1023));
        r = $urandom_range(0, 9);
        if (r < 2) val[3:0] = 4'd0;
        else if (r < 4) val[3:0] = 4'd15;
        write_register(swr_pkg::CFG_MAX_RETRIES, val);
        r = $urandom_range(0, 19);
        if (r < 2) val = 10'd0;
        else if (r < 6) val = 10'd1;
        else if (r == 6) val = 10'h3FF;
        else if (r == 7) val = 10'($urandom_range(30, 150));
        else val = 10'($urandom_range(2, 8));
        write_register(swr_pkg::CFG_TIMEOUT_POLLS, val);
        phase_left = $urandom_range(2, 8);
      end
      run_message();
      phase_left--;
      // Items while idle are ignored by the block.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: offer(swr_pkg::MODE_POLL, $urandom);
            1: offer(swr_pkg::MODE_ACK, $urandom);
            default: offer(swr_pkg::MODE_LINK_ERR, $urandom);
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver pacing: free runs, short and long stalls, and rare long holds
  // that let the block fill up and stall its input.
  initial begin : receiver_pacing
    int n;
    int r;
    int hold_at;
    hold_at = 300;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (reports_seen >= hold_at) begin
        hold_at += 500;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_stall <= (r < 70) ? 1'b0 : 1'b1;
        n = $urandom_range(1, 3);
      end else if (r < 97) begin
        out_stall <= 1'b1;
        n = $urandom_range(4, 12);
      end else begin
        out_stall <= 1'b1;
        n = $urandom_range(20, 60);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Compare each accepted report with the oldest prediction.
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: expected no report, actual kind=%0d id=%h attempt=%0d", $time,
                 event_kind, out_id, attempt_no);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        if (event_kind !== want.kind) begin
          $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, event_kind);
          mismatches++;
        end
        if (out_id !== want.id) begin
          $display("%0t: out_id expected %h actual %h", $time, want.id, out_id);
          mismatches++;
        end
        if (attempt_no !== want.attempt) begin
          $display("%0t: attempt_no expected %0d actual %0d", $time, want.attempt,
                   attempt_no);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
